// ===== design/eilc_pkg.sv =====
package eilc_pkg;

    // Fixed widths of the payload fields
    localparam int FIELD_W   = 16;
    localparam int IRQ_W     = 7;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam int LINE_COUNT_DEFAULT = 16;

    // IRQ grouping: lines below SINGLE_LINES each drive their own output,
    // then one output for lines GROUP_A_LO..GROUP_A_HI, one for the rest
    localparam int SINGLE_LINES = 5;
    localparam int GROUP_A_LO   = 5;
    localparam int GROUP_A_HI   = 9;
    localparam int GROUP_B_LO   = 10;
    localparam int GROUP_B_HI   = 15;
    localparam int IRQ_GROUP_A  = 5;
    localparam int IRQ_GROUP_B  = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_TRIGGER = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_READ    = 2'd3
    } t_command;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RISING_ENABLE    = 2'd0,
        REG_FALLING_ENABLE   = 2'd1,
        REG_INTERRUPT_ENABLE = 2'd2,
        REG_UNUSED           = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic [FIELD_W-1:0] pending_lines;
        logic [IRQ_W-1:0]   irq_outputs;
    } t_result;

endpackage

// ===== design/eilc_lines.sv =====
module eilc_lines #(
    parameter int LINE_COUNT = eilc_pkg::LINE_COUNT_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [eilc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [eilc_pkg::FIELD_W-1:0]      i_cfg_data,
    input  logic                              i_fire,
    input  eilc_pkg::t_command                i_command,
    input  logic [eilc_pkg::FIELD_W-1:0]      i_pin_levels,
    input  logic [eilc_pkg::FIELD_W-1:0]      i_line_mask,
    output eilc_pkg::t_result                 o_result
);

    // Inputs are 16 bits wide, so no line above that can ever become pending
    localparam int ACTIVE_LINES =
        (LINE_COUNT < eilc_pkg::FIELD_W) ? LINE_COUNT : eilc_pkg::FIELD_W;

    logic [ACTIVE_LINES-1:0] r_rise_en, r_fall_en, r_irq_en;
    logic [ACTIVE_LINES-1:0] r_prev, r_pend, r_swreq;
    logic [ACTIVE_LINES-1:0] n_prev, n_pend, n_swreq;
    logic [ACTIVE_LINES-1:0] pins, sel, act;
    logic [eilc_pkg::FIELD_W-1:0] act_ext;
    eilc_pkg::t_reg_index cfg_idx;

    assign pins    = i_pin_levels[ACTIVE_LINES-1:0];
    assign sel     = i_line_mask[ACTIVE_LINES-1:0];
    assign cfg_idx = eilc_pkg::t_reg_index'(i_cfg_index);

    always_comb begin
        n_prev  = r_prev;
        n_pend  = r_pend;
        n_swreq = r_swreq;
        unique case (i_command)
            eilc_pkg::CMD_SAMPLE: begin
                n_pend = r_pend | (pins & ~r_prev & r_rise_en)
                                | (~pins & r_prev & r_fall_en);
                n_prev = pins;
            end
            eilc_pkg::CMD_TRIGGER: begin
                n_pend  = r_pend | sel;
                n_swreq = r_swreq | sel;
            end
            eilc_pkg::CMD_CLEAR: begin
                n_pend  = r_pend & ~sel;
                n_swreq = r_swreq & ~sel;
            end
            eilc_pkg::CMD_READ: begin
            end
            default: begin
            end
        endcase
    end

    // The enable mask gates the IRQ only, never the pending bit
    assign act     = n_pend & r_irq_en;
    assign act_ext = eilc_pkg::FIELD_W'(act);

    always_comb begin
        o_result.pending_lines = eilc_pkg::FIELD_W'(n_pend);
        o_result.irq_outputs   = '0;
        o_result.irq_outputs[eilc_pkg::SINGLE_LINES-1:0] =
            act_ext[eilc_pkg::SINGLE_LINES-1:0];
        o_result.irq_outputs[eilc_pkg::IRQ_GROUP_A] =
            |act_ext[eilc_pkg::GROUP_A_HI:eilc_pkg::GROUP_A_LO];
        o_result.irq_outputs[eilc_pkg::IRQ_GROUP_B] =
            |act_ext[eilc_pkg::GROUP_B_HI:eilc_pkg::GROUP_B_LO];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_en <= '0;
            r_fall_en <= '0;
            r_irq_en  <= '0;
            r_prev    <= '0;
            r_pend    <= '0;
            r_swreq   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (cfg_idx)
                    eilc_pkg::REG_RISING_ENABLE:    r_rise_en <= i_cfg_data[ACTIVE_LINES-1:0];
                    eilc_pkg::REG_FALLING_ENABLE:   r_fall_en <= i_cfg_data[ACTIVE_LINES-1:0];
                    eilc_pkg::REG_INTERRUPT_ENABLE: r_irq_en  <= i_cfg_data[ACTIVE_LINES-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_fire) begin
                r_prev  <= n_prev;
                r_pend  <= n_pend;
                r_swreq <= n_swreq;
            end
        end
    end

endmodule

// ===== design/external_interrupt_line_controller_unit.sv =====
// Each result word is registered in the output slot, or in the skid slot while output is stalled.
// Throughput: one word per cycle while the skid slot is empty; the line state update is
// a single pass of gate logic between the state registers, and a two-deep output buffer
// keeps input ready high until a stalled output leaves a word waiting in the skid slot.
// Reset (synchronous, active low) clears the enable masks, previous levels,
// pending and software-request bits, and empties the output buffer.
module external_interrupt_line_controller_unit #(
    parameter int LINE_COUNT = eilc_pkg::LINE_COUNT_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [eilc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [eilc_pkg::FIELD_W-1:0]      i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [eilc_pkg::CMD_W-1:0]        i_command,
    input  logic [eilc_pkg::FIELD_W-1:0]      i_pin_levels,
    input  logic [eilc_pkg::FIELD_W-1:0]      i_line_mask,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [eilc_pkg::FIELD_W-1:0]      o_pending_lines,
    output logic [eilc_pkg::IRQ_W-1:0]        o_irq_outputs
);

    logic              in_fire;
    eilc_pkg::t_result result;
    eilc_pkg::t_result r_out, r_skid;
    logic              r_out_valid, r_skid_valid;

    assign o_ready = !r_skid_valid;
    assign in_fire = i_valid && o_ready;

    eilc_lines #(
        .LINE_COUNT (LINE_COUNT)
    ) u_lines (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_fire       (in_fire),
        .i_command    (eilc_pkg::t_command'(i_command)),
        .i_pin_levels (i_pin_levels),
        .i_line_mask  (i_line_mask),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            // output slot free: drain the skid word first, else take the new word
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out <= r_skid_valid ? r_skid : result;
        end else if (in_fire) begin
            r_skid <= result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pending_lines = r_out.pending_lines;
    assign o_irq_outputs   = r_out.irq_outputs;

endmodule
